### hw/rtl/gcol_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcol_pkg: shared types and constants
// Sizes, operation and status codes, queue item and back-end states for the
// greedy graph coloring engine.
// ----------------------------------------------------------------------------
package gcol_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int VIDX_W       = 10;
    localparam int CNT_W        = 11;
    localparam int MAX_EDGES    = 8192;
    localparam int EIDX_W       = 13;
    localparam int ECNT_W       = 14;
    localparam int WORD_BITS    = 32;
    localparam int BIT_W        = 5;
    localparam int FORB_WORDS   = MAX_VERTICES / WORD_BITS + 2;
    localparam int FW_W         = 6;
    localparam int COLOR_W      = 11;
    localparam int COLOR_LIMIT  = FORB_WORDS * WORD_BITS - 1;
    localparam int DEGREE_MAX   = 2047;
    localparam int QUEUE_DEPTH  = 2;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_RUN   = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_ORDER = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        op_t               op;
        logic [VIDX_W-1:0] vertex;
        logic [VIDX_W-1:0] neighbor;
        logic              in_range;
    } item_t;

    typedef enum logic [4:0] {
        BS_SWEEP,
        BS_IDLE,
        BS_ADD_FILL,
        BS_ADD_STORE,
        BS_READ_REQ,
        BS_READ_DATA,
        BS_RESULT,
        BS_PASS_START,
        BS_A_CHECK,
        BS_A_CONF,
        BS_BND1,
        BS_BND2,
        BS_A_NB,
        BS_A_NB1,
        BS_A_NB2,
        BS_A_NB3,
        BS_A_SCAN,
        BS_A_SCAN1,
        BS_A_WRITE,
        BS_D_CHECK,
        BS_D_OWN,
        BS_D_NB,
        BS_D_NB1,
        BS_D_NB2,
        BS_PASS_END,
        BS_M_CHECK,
        BS_M_DATA
    } bstate_t;

endpackage
`default_nettype wire

### hw/rtl/gcol_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcol_front: input handshake and classification
// Takes items when the queue has room and no clear runs, and range-tags each.
// ----------------------------------------------------------------------------
module gcol_front (
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [1:0]                  operation,
    input  wire logic [gcol_pkg::VIDX_W-1:0] vertex,
    input  wire logic [gcol_pkg::VIDX_W-1:0] neighbor,
    input  wire logic [gcol_pkg::CNT_W-1:0]  vertex_count,
    input  wire logic                        q_full,
    input  wire logic                        init_busy,
    output logic                             push,
    output gcol_pkg::item_t                  push_item
);

    logic [gcol_pkg::CNT_W-1:0] n_eff;
    logic                       v_ok;
    logic                       nb_ok;

    always_comb
    begin
        n_eff = (vertex_count > gcol_pkg::CNT_W'(gcol_pkg::MAX_VERTICES))
              ? gcol_pkg::CNT_W'(gcol_pkg::MAX_VERTICES) : vertex_count;
        v_ok  = {1'b0, vertex} < n_eff;
        nb_ok = {1'b0, neighbor} < n_eff;
        push_item.op       = gcol_pkg::op_t'(operation);
        push_item.vertex   = vertex;
        push_item.neighbor = neighbor;
        push_item.in_range = (gcol_pkg::op_t'(operation) == gcol_pkg::OP_ADD)
                           ? (v_ok && nb_ok) : v_ok;
        in_stall = q_full || init_busy;
        push     = in_valid && !in_stall;
    end

endmodule
`default_nettype wire

### hw/rtl/gcol_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcol_queue: short item queue
// Two-entry queue between the front and back ends.
// ----------------------------------------------------------------------------
module gcol_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire gcol_pkg::item_t push_item,
    input  wire logic            pop,
    output gcol_pkg::item_t      head,
    output logic                 full,
    output logic                 empty
);

    gcol_pkg::item_t entry_reg [gcol_pkg::QUEUE_DEPTH];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;

    always_comb
    begin
        full        = count_reg == 2'(gcol_pkg::QUEUE_DEPTH);
        empty       = count_reg == 2'd0;
        head        = entry_reg[rd_ptr_reg];
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/gcol_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcol_back: graph store and coloring sequencer
// Holds the offset table, neighbor store, colors, conflict flags and the
// forbidden bitmap, and steps through loads, reads and coloring passes.
// ----------------------------------------------------------------------------
module gcol_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [gcol_pkg::CNT_W-1:0]  vertex_count,
    input  wire logic                        q_empty,
    input  wire gcol_pkg::item_t             q_head,
    output logic                             q_pop,
    output logic                             init_busy,
    input  wire logic                        out_stall,
    output logic                             out_valid,
    output logic [gcol_pkg::COLOR_W-1:0]     value,
    output gcol_pkg::status_t                status
);

    localparam int VW = gcol_pkg::VIDX_W;
    localparam int CW = gcol_pkg::CNT_W;
    localparam int EW = gcol_pkg::ECNT_W;
    localparam int XW = gcol_pkg::EIDX_W;
    localparam int KW = gcol_pkg::COLOR_W;
    localparam int FW = gcol_pkg::FW_W;
    localparam int BW = gcol_pkg::BIT_W;
    localparam int WB = gcol_pkg::WORD_BITS;

    logic [EW-1:0] off_mem   [gcol_pkg::MAX_VERTICES];
    logic [VW-1:0] store_mem [gcol_pkg::MAX_EDGES];
    logic [KW-1:0] color_mem [gcol_pkg::MAX_VERTICES];
    logic          conf_mem  [gcol_pkg::MAX_VERTICES];
    logic [WB-1:0] forb_mem  [gcol_pkg::FORB_WORDS];

    logic [EW-1:0] off_rdata_reg;
    logic [VW-1:0] store_rdata_reg;
    logic [KW-1:0] color_rdata_reg;
    logic          conf_rdata_reg;
    logic [WB-1:0] forb_rdata_reg;

    logic          off_we;
    logic [VW-1:0] off_wa;
    logic [EW-1:0] off_wd;
    logic [VW-1:0] off_ra;
    logic          store_we;
    logic [XW-1:0] store_wa;
    logic [VW-1:0] store_wd;
    logic [XW-1:0] store_ra;
    logic          color_we;
    logic [VW-1:0] color_wa;
    logic [KW-1:0] color_wd;
    logic [VW-1:0] color_ra;
    logic          conf_we;
    logic [VW-1:0] conf_wa;
    logic          conf_wd;
    logic [VW-1:0] conf_ra;
    logic          forb_we;
    logic [FW-1:0] forb_wa;
    logic [WB-1:0] forb_wd;
    logic [FW-1:0] forb_ra;

    gcol_pkg::bstate_t state_reg, state_next;
    gcol_pkg::item_t   item_reg, item_next;
    gcol_pkg::status_t res_status_reg, res_status_next;
    gcol_pkg::status_t status_reg, status_next;
    logic [VW-1:0] sweep_reg, sweep_next;
    logic          run_mode_reg, run_mode_next;
    logic [EW-1:0] ec_reg, ec_next;
    logic [VW-1:0] cv_reg, cv_next;
    logic [EW-1:0] cur_start_reg, cur_start_next;
    logic [CW-1:0] max_deg_reg, max_deg_next;
    logic          any_conf_reg, any_conf_next;
    logic [CW-1:0] pass_reg, pass_next;
    logic [CW-1:0] i_reg, i_next;
    logic [EW-1:0] k_reg, k_next;
    logic [EW-1:0] kend_reg, kend_next;
    logic [VW-1:0] fill_reg, fill_next;
    logic          detect_reg, detect_next;
    logic [KW-1:0] c_reg, c_next;
    logic [FW-1:0] w_reg, w_next;
    logic          found_reg, found_next;
    logic [KW-1:0] new_color_reg, new_color_next;
    logic [KW-1:0] own_reg, own_next;
    logic [KW-1:0] best_reg, best_next;
    logic [KW-1:0] res_value_reg, res_value_next;
    logic          out_valid_reg, out_valid_next;
    logic [KW-1:0] value_reg, value_next;

    logic [CW-1:0] n_eff;
    logic [KW:0]   top_sum;
    logic [KW-1:0] top_color;
    logic [EW-1:0] ec_inc;
    logic [EW-1:0] add_start;
    logic [EW-1:0] add_deg;
    logic [CW-1:0] add_deg_sat;
    logic [CW-1:0] i_inc;
    logic [KW-1:0] scan_cand;
    logic          scan_hit;
    logic [BW-1:0] scan_pos;

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;
    assign init_busy = (state_reg == gcol_pkg::BS_SWEEP) && !run_mode_reg;

    always_comb
    begin
        n_eff = (vertex_count > CW'(gcol_pkg::MAX_VERTICES))
              ? CW'(gcol_pkg::MAX_VERTICES) : vertex_count;
        top_sum   = {1'b0, max_deg_reg} + (KW+1)'(1);
        top_color = (top_sum > (KW+1)'(gcol_pkg::COLOR_LIMIT))
                  ? KW'(gcol_pkg::COLOR_LIMIT) : top_sum[KW-1:0];
        ec_inc    = ec_reg + EW'(1);
        add_start = (item_reg.vertex != cv_reg) ? ec_reg : cur_start_reg;
        add_deg   = ec_inc - add_start;
        add_deg_sat = (add_deg > EW'(gcol_pkg::DEGREE_MAX))
                    ? CW'(gcol_pkg::DEGREE_MAX) : add_deg[CW-1:0];
        i_inc     = i_reg + CW'(1);
    end

    always_comb
    begin
        scan_hit  = 1'b0;
        scan_pos  = '0;
        scan_cand = '0;
        for (int b = WB - 1; b >= 0; b--)
        begin
            scan_cand = {w_reg, BW'(b)};
            if (!forb_rdata_reg[b] && (scan_cand != '0) && (scan_cand <= top_color))
            begin
                scan_hit = 1'b1;
                scan_pos = BW'(b);
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        sweep_next      = sweep_reg;
        run_mode_next   = run_mode_reg;
        ec_next         = ec_reg;
        cv_next         = cv_reg;
        cur_start_next  = cur_start_reg;
        max_deg_next    = max_deg_reg;
        any_conf_next   = any_conf_reg;
        pass_next       = pass_reg;
        i_next          = i_reg;
        k_next          = k_reg;
        kend_next       = kend_reg;
        fill_next       = fill_reg;
        detect_next     = detect_reg;
        c_next          = c_reg;
        w_next          = w_reg;
        found_next      = found_reg;
        new_color_next  = new_color_reg;
        own_next        = own_reg;
        best_next       = best_reg;
        value_next      = value_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && out_stall;
        q_pop           = 1'b0;
        off_we   = 1'b0; off_wa   = '0; off_wd   = '0; off_ra   = '0;
        store_we = 1'b0; store_wa = '0; store_wd = '0; store_ra = '0;
        color_we = 1'b0; color_wa = '0; color_wd = '0; color_ra = '0;
        conf_we  = 1'b0; conf_wa  = '0; conf_wd  = 1'b0; conf_ra = '0;
        forb_we  = 1'b0; forb_wa  = '0; forb_wd  = '0; forb_ra  = '0;

        unique case (state_reg)
            gcol_pkg::BS_SWEEP:
            begin
                color_we = 1'b1;
                color_wa = sweep_reg;
                conf_we  = 1'b1;
                conf_wa  = sweep_reg;
                conf_wd  = 1'b1;
                if (sweep_reg < VW'(gcol_pkg::FORB_WORDS))
                begin
                    forb_we = 1'b1;
                    forb_wa = sweep_reg[FW-1:0];
                end
                sweep_next = sweep_reg + VW'(1);
                if (sweep_reg == VW'(gcol_pkg::MAX_VERTICES - 1))
                begin
                    state_next = run_mode_reg ? gcol_pkg::BS_PASS_START
                                              : gcol_pkg::BS_IDLE;
                end
            end
            gcol_pkg::BS_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    item_next = q_head;
                    res_value_next = '0;
                    unique case (q_head.op)
                        gcol_pkg::OP_ADD:
                        begin
                            if (!q_head.in_range)
                            begin
                                res_status_next = gcol_pkg::ST_RANGE;
                                state_next      = gcol_pkg::BS_RESULT;
                            end
                            else if (q_head.vertex < cv_reg)
                            begin
                                res_status_next = gcol_pkg::ST_ORDER;
                                state_next      = gcol_pkg::BS_RESULT;
                            end
                            else if (ec_reg == EW'(gcol_pkg::MAX_EDGES))
                            begin
                                res_status_next = gcol_pkg::ST_FULL;
                                state_next      = gcol_pkg::BS_RESULT;
                            end
                            else if (q_head.vertex > cv_reg)
                            begin
                                fill_next  = cv_reg + VW'(1);
                                state_next = gcol_pkg::BS_ADD_FILL;
                            end
                            else
                            begin
                                state_next = gcol_pkg::BS_ADD_STORE;
                            end
                        end
                        gcol_pkg::OP_RUN:
                        begin
                            run_mode_next = 1'b1;
                            sweep_next    = '0;
                            pass_next     = '0;
                            state_next    = gcol_pkg::BS_SWEEP;
                        end
                        gcol_pkg::OP_READ:
                        begin
                            if (q_head.in_range)
                            begin
                                state_next = gcol_pkg::BS_READ_REQ;
                            end
                            else
                            begin
                                res_status_next = gcol_pkg::ST_RANGE;
                                state_next      = gcol_pkg::BS_RESULT;
                            end
                        end
                        gcol_pkg::OP_CLEAR:
                        begin
                            ec_next        = '0;
                            cv_next        = '0;
                            cur_start_next = '0;
                            max_deg_next   = '0;
                            any_conf_next  = 1'b0;
                            run_mode_next  = 1'b0;
                            sweep_next     = '0;
                            state_next     = gcol_pkg::BS_SWEEP;
                        end
                        default:
                        begin
                            state_next = gcol_pkg::BS_IDLE;
                        end
                    endcase
                end
            end
            gcol_pkg::BS_ADD_FILL:
            begin
                off_we = 1'b1;
                off_wa = fill_reg;
                off_wd = ec_reg;
                fill_next = fill_reg + VW'(1);
                if (fill_reg == item_reg.vertex)
                begin
                    state_next = gcol_pkg::BS_ADD_STORE;
                end
            end
            gcol_pkg::BS_ADD_STORE:
            begin
                store_we       = 1'b1;
                store_wa       = ec_reg[XW-1:0];
                store_wd       = item_reg.neighbor;
                ec_next        = ec_inc;
                cv_next        = item_reg.vertex;
                cur_start_next = add_start;
                if (add_deg_sat > max_deg_reg)
                begin
                    max_deg_next = add_deg_sat;
                end
                state_next = gcol_pkg::BS_IDLE;
            end
            gcol_pkg::BS_READ_REQ:
            begin
                color_ra   = item_reg.vertex;
                state_next = gcol_pkg::BS_READ_DATA;
            end
            gcol_pkg::BS_READ_DATA:
            begin
                res_value_next  = color_rdata_reg;
                res_status_next = gcol_pkg::ST_OK;
                state_next      = gcol_pkg::BS_RESULT;
            end
            gcol_pkg::BS_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    value_next     = res_value_reg;
                    status_next    = res_status_reg;
                    state_next     = gcol_pkg::BS_IDLE;
                end
            end
            gcol_pkg::BS_PASS_START:
            begin
                any_conf_next = 1'b0;
                i_next        = '0;
                state_next    = gcol_pkg::BS_A_CHECK;
            end
            gcol_pkg::BS_A_CHECK:
            begin
                if (i_reg == n_eff)
                begin
                    i_next     = '0;
                    state_next = gcol_pkg::BS_D_CHECK;
                end
                else
                begin
                    conf_ra    = i_reg[VW-1:0];
                    state_next = gcol_pkg::BS_A_CONF;
                end
            end
            gcol_pkg::BS_A_CONF:
            begin
                if (!conf_rdata_reg)
                begin
                    i_next     = i_inc;
                    state_next = gcol_pkg::BS_A_CHECK;
                end
                else
                begin
                    detect_next = 1'b0;
                    off_ra      = i_reg[VW-1:0];
                    state_next  = gcol_pkg::BS_BND1;
                end
            end
            gcol_pkg::BS_BND1:
            begin
                if (i_reg == '0)
                begin
                    k_next = '0;
                end
                else if (i_reg <= {1'b0, cv_reg})
                begin
                    k_next = off_rdata_reg;
                end
                else
                begin
                    k_next = ec_reg;
                end
                off_ra     = i_inc[VW-1:0];
                state_next = gcol_pkg::BS_BND2;
            end
            gcol_pkg::BS_BND2:
            begin
                kend_next  = (i_inc <= {1'b0, cv_reg}) ? off_rdata_reg : ec_reg;
                found_next = 1'b0;
                w_next     = '0;
                state_next = detect_reg ? gcol_pkg::BS_D_NB : gcol_pkg::BS_A_NB;
            end
            gcol_pkg::BS_A_NB:
            begin
                if (k_reg == kend_reg)
                begin
                    w_next     = '0;
                    state_next = gcol_pkg::BS_A_SCAN;
                end
                else
                begin
                    store_ra   = k_reg[XW-1:0];
                    state_next = gcol_pkg::BS_A_NB1;
                end
            end
            gcol_pkg::BS_A_NB1:
            begin
                if ({1'b0, store_rdata_reg} >= n_eff)
                begin
                    k_next     = k_reg + EW'(1);
                    state_next = gcol_pkg::BS_A_NB;
                end
                else
                begin
                    color_ra   = store_rdata_reg;
                    state_next = gcol_pkg::BS_A_NB2;
                end
            end
            gcol_pkg::BS_A_NB2:
            begin
                c_next     = color_rdata_reg;
                forb_ra    = color_rdata_reg[KW-1:BW];
                state_next = gcol_pkg::BS_A_NB3;
            end
            gcol_pkg::BS_A_NB3:
            begin
                forb_we    = 1'b1;
                forb_wa    = c_reg[KW-1:BW];
                forb_wd    = forb_rdata_reg | (WB'(1) << c_reg[BW-1:0]);
                k_next     = k_reg + EW'(1);
                state_next = gcol_pkg::BS_A_NB;
            end
            gcol_pkg::BS_A_SCAN:
            begin
                forb_ra    = w_reg;
                state_next = gcol_pkg::BS_A_SCAN1;
            end
            gcol_pkg::BS_A_SCAN1:
            begin
                forb_we = 1'b1;
                forb_wa = w_reg;
                if (scan_hit && !found_reg)
                begin
                    found_next     = 1'b1;
                    new_color_next = {w_reg, scan_pos};
                end
                w_next = w_reg + FW'(1);
                if (w_reg == FW'(gcol_pkg::FORB_WORDS - 1))
                begin
                    state_next = gcol_pkg::BS_A_WRITE;
                end
                else
                begin
                    state_next = gcol_pkg::BS_A_SCAN;
                end
            end
            gcol_pkg::BS_A_WRITE:
            begin
                if (found_reg)
                begin
                    color_we = 1'b1;
                    color_wa = i_reg[VW-1:0];
                    color_wd = new_color_reg;
                end
                i_next     = i_inc;
                state_next = gcol_pkg::BS_A_CHECK;
            end
            gcol_pkg::BS_D_CHECK:
            begin
                if (i_reg == n_eff)
                begin
                    state_next = gcol_pkg::BS_PASS_END;
                end
                else
                begin
                    color_ra   = i_reg[VW-1:0];
                    state_next = gcol_pkg::BS_D_OWN;
                end
            end
            gcol_pkg::BS_D_OWN:
            begin
                own_next    = color_rdata_reg;
                detect_next = 1'b1;
                off_ra      = i_reg[VW-1:0];
                state_next  = gcol_pkg::BS_BND1;
            end
            gcol_pkg::BS_D_NB:
            begin
                if (k_reg == kend_reg)
                begin
                    conf_we    = 1'b1;
                    conf_wa    = i_reg[VW-1:0];
                    conf_wd    = 1'b0;
                    i_next     = i_inc;
                    state_next = gcol_pkg::BS_D_CHECK;
                end
                else
                begin
                    store_ra   = k_reg[XW-1:0];
                    state_next = gcol_pkg::BS_D_NB1;
                end
            end
            gcol_pkg::BS_D_NB1:
            begin
                if ({1'b0, store_rdata_reg} < i_reg)
                begin
                    color_ra   = store_rdata_reg;
                    state_next = gcol_pkg::BS_D_NB2;
                end
                else
                begin
                    k_next     = k_reg + EW'(1);
                    state_next = gcol_pkg::BS_D_NB;
                end
            end
            gcol_pkg::BS_D_NB2:
            begin
                if (color_rdata_reg == own_reg)
                begin
                    conf_we       = 1'b1;
                    conf_wa       = i_reg[VW-1:0];
                    conf_wd       = 1'b1;
                    any_conf_next = 1'b1;
                    i_next        = i_inc;
                    state_next    = gcol_pkg::BS_D_CHECK;
                end
                else
                begin
                    k_next     = k_reg + EW'(1);
                    state_next = gcol_pkg::BS_D_NB;
                end
            end
            gcol_pkg::BS_PASS_END:
            begin
                pass_next = pass_reg + CW'(1);
                if (any_conf_reg && (pass_next < CW'(gcol_pkg::MAX_VERTICES)))
                begin
                    state_next = gcol_pkg::BS_PASS_START;
                end
                else
                begin
                    i_next     = '0;
                    best_next  = '0;
                    state_next = gcol_pkg::BS_M_CHECK;
                end
            end
            gcol_pkg::BS_M_CHECK:
            begin
                if (i_reg == n_eff)
                begin
                    res_value_next  = best_reg;
                    res_status_next = gcol_pkg::ST_OK;
                    run_mode_next   = 1'b0;
                    state_next      = gcol_pkg::BS_RESULT;
                end
                else
                begin
                    color_ra   = i_reg[VW-1:0];
                    state_next = gcol_pkg::BS_M_DATA;
                end
            end
            gcol_pkg::BS_M_DATA:
            begin
                if (color_rdata_reg > best_reg)
                begin
                    best_next = color_rdata_reg;
                end
                i_next     = i_inc;
                state_next = gcol_pkg::BS_M_CHECK;
            end
            default:
            begin
                state_next = gcol_pkg::BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gcol_pkg::BS_SWEEP;
            sweep_reg     <= '0;
            run_mode_reg  <= 1'b0;
            ec_reg        <= '0;
            cv_reg        <= '0;
            cur_start_reg <= '0;
            max_deg_reg   <= '0;
            any_conf_reg  <= 1'b0;
            pass_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            run_mode_reg  <= run_mode_next;
            ec_reg        <= ec_next;
            cv_reg        <= cv_next;
            cur_start_reg <= cur_start_next;
            max_deg_reg   <= max_deg_next;
            any_conf_reg  <= any_conf_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        status_reg     <= status_next;
        value_reg      <= value_next;
        i_reg          <= i_next;
        k_reg          <= k_next;
        kend_reg       <= kend_next;
        fill_reg       <= fill_next;
        detect_reg     <= detect_next;
        c_reg          <= c_next;
        w_reg          <= w_next;
        found_reg      <= found_next;
        new_color_reg  <= new_color_next;
        own_reg        <= own_next;
        best_reg       <= best_next;
    end

    always_ff @(posedge clk)
    begin
        if (off_we)
        begin
            off_mem[off_wa] <= off_wd;
        end
        off_rdata_reg <= off_mem[off_ra];
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[store_wa] <= store_wd;
        end
        store_rdata_reg <= store_mem[store_ra];
    end

    always_ff @(posedge clk)
    begin
        if (color_we)
        begin
            color_mem[color_wa] <= color_wd;
        end
        color_rdata_reg <= color_mem[color_ra];
    end

    always_ff @(posedge clk)
    begin
        if (conf_we)
        begin
            conf_mem[conf_wa] <= conf_wd;
        end
        conf_rdata_reg <= conf_mem[conf_ra];
    end

    always_ff @(posedge clk)
    begin
        if (forb_we)
        begin
            forb_mem[forb_wa] <= forb_wd;
        end
        forb_rdata_reg <= forb_mem[forb_ra];
    end

endmodule
`default_nettype wire

### hw/rtl/greedy_graph_coloring_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// greedy_graph_coloring_engine: iterative speculative greedy graph coloring
// Loads adjacency lists, runs coloring passes until conflict free or the
// pass limit is reached, and answers color reads.
// ----------------------------------------------------------------------------
// Add: fills the offset of each vertex it advances past the current one, then
// stores the neighbor; read: fetches the color. Run: a clearing sweep, then
// per pass assigns colors to conflicting vertices and detects conflicts, then
// takes the final maximum. Clear graph: a clearing sweep.
// Reset: a clearing pass follows reset; no item is taken until it ends.
// Configuration writes are taken at any time.
module greedy_graph_coloring_engine (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        vertex_count_we,
    input  wire logic [10:0] vertex_count_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  operation,
    input  wire logic [9:0]  vertex,
    input  wire logic [9:0]  neighbor,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [10:0]      value,
    output logic [1:0]       status
);

    logic [gcol_pkg::CNT_W-1:0] vertex_count_reg;
    logic [gcol_pkg::CNT_W-1:0] vertex_count_next;
    logic                       q_push;
    logic                       q_pop;
    logic                       q_full;
    logic                       q_empty;
    logic                       init_busy;
    gcol_pkg::item_t            push_item;
    gcol_pkg::item_t            q_head;
    gcol_pkg::status_t          status_int;

    assign vertex_count_next = vertex_count_we ? vertex_count_data : vertex_count_reg;
    assign status            = status_int;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= gcol_pkg::CNT_W'(1);
        end
        else
        begin
            vertex_count_reg <= vertex_count_next;
        end
    end

    gcol_front u_front (
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .vertex       (vertex),
        .neighbor     (neighbor),
        .vertex_count (vertex_count_reg),
        .q_full       (q_full),
        .init_busy    (init_busy),
        .push         (q_push),
        .push_item    (push_item)
    );

    gcol_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    gcol_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertex_count (vertex_count_reg),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .init_busy    (init_busy),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .value        (value),
        .status       (status_int)
    );

    a_error_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status_int != gcol_pkg::ST_OK)) |-> (value == '0))
        else $error("error item carries a nonzero value");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("back end popped an empty queue");

    a_no_take_while_init: assert property (@(posedge clk) disable iff (!rst_n)
        init_busy |-> in_stall)
        else $error("item taken during clearing pass");

endmodule
`default_nettype wire

### verif/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: testbench for greedy_graph_coloring_engine
// Loads adjacency lists, runs coloring and reads vertex colors under random
// gaps and back-pressure. Every result is compared with a local coloring
// predictor that runs the same speculative greedy passes.
// ----------------------------------------------------------------------------
typedef struct {
    logic [10:0]       value;
    gcol_pkg::status_t status;
} color_result_t;

class coloring_scoreboard;
    int            offs [gcol_pkg::MAX_VERTICES+1];
    int            nbs  [gcol_pkg::MAX_EDGES];
    int            col  [gcol_pkg::MAX_VERTICES];
    bit            conf [gcol_pkg::MAX_VERTICES];
    int            ecount;
    int            curv;
    int            maxdeg;
    int            vcount;
    color_result_t pending [$];
    int            errors;

    function new();
        clear_graph();
        vcount = 1;
        errors = 0;
    endfunction

    function void clear_graph();
        foreach (offs[i]) offs[i] = 0;
        foreach (nbs[i]) nbs[i] = 0;
        foreach (col[i]) col[i] = 0;
        foreach (conf[i]) conf[i] = 1;
        ecount = 0;
        curv   = 0;
        maxdeg = 0;
    endfunction

    function int eff();
        return (vcount > gcol_pkg::MAX_VERTICES) ? gcol_pkg::MAX_VERTICES : vcount;
    endfunction

    function int lstart(int i);
        return (i <= curv) ? offs[i] : ecount;
    endfunction

    function int run_coloring();
        int n;
        int passes;
        int best;
        int top;
        int e;
        int j;
        bit anyc;
        logic [gcol_pkg::COLOR_LIMIT:0] forb;
        n = eff();
        passes = 0;
        best = 0;
        foreach (col[i]) col[i] = 0;
        foreach (conf[i]) conf[i] = 1;
        do begin
            anyc = 0;
            top = maxdeg + 1;
            if (top > gcol_pkg::COLOR_LIMIT) top = gcol_pkg::COLOR_LIMIT;
            for (int i = 0; i < n; i++) begin
                if (conf[i])
                begin
                    forb = '0;
                    e = lstart(i + 1);
                    for (int k = lstart(i); k < e && k < gcol_pkg::MAX_EDGES; k++)
                    begin
                        j = nbs[k];
                        if (j < n) forb[col[j]] = 1'b1;
                    end
                    for (int c = 1; c <= top; c++)
                    begin
                        if (!forb[c])
                        begin
                            col[i] = c;
                            break;
                        end
                    end
                end
            end
            for (int v = 0; v < n; v++)
            begin
                conf[v] = 0;
                e = lstart(v + 1);
                for (int k = lstart(v); k < e && k < gcol_pkg::MAX_EDGES; k++)
                begin
                    j = nbs[k];
                    if (j < v && col[j] == col[v])
                    begin
                        conf[v] = 1;
                        anyc = 1;
                        break;
                    end
                end
            end
            passes++;
        end while (anyc && passes < gcol_pkg::MAX_VERTICES);
        for (int i = 0; i < n; i++)
            if (col[i] > best) best = col[i];
        return best;
    endfunction

    function gcol_pkg::status_t add_entry(int v, int nb);
        int deg;
        if (v >= eff() || nb >= eff()) return gcol_pkg::ST_RANGE;
        if (v < curv) return gcol_pkg::ST_ORDER;
        if (ecount >= gcol_pkg::MAX_EDGES) return gcol_pkg::ST_FULL;
        for (int k = curv + 1; k <= v; k++) offs[k] = ecount;
        curv = v;
        nbs[ecount] = nb;
        ecount++;
        deg = ecount - offs[v];
        if (deg > gcol_pkg::DEGREE_MAX) deg = gcol_pkg::DEGREE_MAX;
        if (deg > maxdeg) maxdeg = deg;
        return gcol_pkg::ST_OK;
    endfunction

    function void note_item(gcol_pkg::op_t op, int v, int nb);
        color_result_t r;
        r.value  = '0;
        r.status = gcol_pkg::ST_OK;
        case (op)
            gcol_pkg::OP_ADD:
            begin
                r.status = add_entry(v, nb);
                if (r.status != gcol_pkg::ST_OK) pending.push_back(r);
            end
            gcol_pkg::OP_RUN:
            begin
                r.value = 11'(run_coloring());
                pending.push_back(r);
            end
            gcol_pkg::OP_READ:
            begin
                if (v < eff()) r.value = 11'(col[v]);
                else r.status = gcol_pkg::ST_RANGE;
                pending.push_back(r);
            end
            default: clear_graph();
        endcase
    endfunction

    function void check_result(logic [10:0] value, logic [1:0] status);
        color_result_t r;
        if (pending.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected result: value %0d status %0d", value, status);
            return;
        end
        r = pending.pop_front();
        if (value !== r.value || status !== r.status)
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch: expected value %0d status %0d, got value %0d status %0d",
                         r.value, r.status, value, status);
        end
    endfunction
endclass

module tb_top;
    localparam int WATCHDOG_LIMIT = 600000;

    logic        clk;
    logic        rst_n;
    logic        vertex_count_we;
    logic [10:0] vertex_count_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  operation;
    logic [9:0]  vertex;
    logic [9:0]  neighbor;
    logic        out_valid;
    logic        out_stall;
    logic [10:0] value;
    logic [1:0]  status;

    coloring_scoreboard sb;
    bit steady;
    bit hold_req;
    int hold_left;
    int stall_cycles;
    int items_sent;
    int big_runs;

    greedy_graph_coloring_engine dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .vertex_count_we   (vertex_count_we),
        .vertex_count_data (vertex_count_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .operation         (operation),
        .vertex            (vertex),
        .neighbor          (neighbor),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .value             (value),
        .status            (status)
    );

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver: random stall, long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req  <= 1'b0;
            hold_left <= 600;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= steady ? 1'b0 : ($urandom_range(99) < 27);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(value, status);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > WATCHDOG_LIMIT)
        begin
            $display("** greedy_graph_coloring_engine: FAILED **");
            $finish;
        end
    end

    task automatic send_item(gcol_pkg::op_t op, int v, int nb);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 27)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        operation = op;
        vertex    = v[9:0];
        neighbor  = nb[9:0];
        in_valid  = 1'b1;
        do @(posedge clk); while (in_stall);
        sb.note_item(op, int'(v[9:0]), int'(nb[9:0]));
        items_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
    endtask

    task automatic write_count(int c);
        drain();
        repeat (1100) @(negedge clk);
        vertex_count_we   = 1'b1;
        vertex_count_data = c[10:0];
        sb.vcount = c;
        @(negedge clk);
        vertex_count_we = 1'b0;
    endtask

    task automatic graph_phase(int ph);
        int cnt;
        int n;
        int v;
        int r;
        int step_max;
        r = $urandom_range(99);
        if (r < 4) cnt = 0;
        else if (r < 8) cnt = 1;
        else if (r < 14 && big_runs < 2)
        begin
            cnt = (big_runs == 0) ? 1024 : 2047;
            big_runs++;
        end
        else cnt = $urandom_range(2, 24);
        write_count(cnt);
        n = sb.eff();
        step_max = (n > 24) ? 120 : 3;
        send_item(gcol_pkg::OP_CLEAR, $urandom_range(1023), $urandom_range(1023));
        v = 0;
        while (n > 0 && v < n)
        begin
            repeat ($urandom_range(0, 5))
            begin
                if ($urandom_range(99) < 10)
                begin
                    if (n <= 24) send_item(gcol_pkg::op_t'($urandom_range(3)),
                                           $urandom_range(1023), $urandom_range(1023));
                    else send_item(gcol_pkg::OP_ADD, $urandom_range(1023),
                                   $urandom_range(1023));
                end
                send_item(gcol_pkg::OP_ADD, v, $urandom_range(n - 1));
            end
            v += $urandom_range(1, step_max);
        end
        if (n > 2 && $urandom_range(99) < 20)
        begin
            write_count($urandom_range(1, n - 1));
            n = sb.eff();
        end
        send_item(gcol_pkg::OP_RUN, $urandom_range(1023), $urandom_range(1023));
        if (ph == 1) drain();
        if (ph == 2) hold_req = 1'b1;
        repeat ($urandom_range(3, 6))
        begin
            if (n > 0 && $urandom_range(99) < 85)
                send_item(gcol_pkg::OP_READ, $urandom_range(n - 1), 0);
            else
                send_item(gcol_pkg::OP_READ, $urandom_range(1023), $urandom_range(1023));
        end
    endtask

    initial
    begin
        int ph;
        sb = new();
        rst_n             = 1'b0;
        vertex_count_we   = 1'b0;
        vertex_count_data = 11'd1;
        in_valid          = 1'b0;
        operation         = gcol_pkg::OP_ADD;
        vertex            = '0;
        neighbor          = '0;
        out_stall         = 1'b0;
        hold_req          = 1'b0;
        hold_left         = 0;
        steady            = 1'b0;
        stall_cycles      = 0;
        items_sent        = 0;
        big_runs          = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_item(gcol_pkg::OP_READ, 0, 0);
        send_item(gcol_pkg::OP_RUN, 0, 0);
        send_item(gcol_pkg::OP_ADD, 1, 0);
        send_item(gcol_pkg::OP_ADD, 0, 1023);
        send_item(gcol_pkg::OP_ADD, 0, 0);
        send_item(gcol_pkg::OP_RUN, 0, 0);
        send_item(gcol_pkg::OP_READ, 0, 0);
        send_item(gcol_pkg::OP_READ, 1023, 1023);
        write_count(0);
        send_item(gcol_pkg::OP_RUN, 0, 0);
        send_item(gcol_pkg::OP_ADD, 0, 0);
        send_item(gcol_pkg::OP_READ, 0, 0);
        write_count(4);
        send_item(gcol_pkg::OP_CLEAR, 0, 0);
        send_item(gcol_pkg::OP_ADD, 2, 1);
        send_item(gcol_pkg::OP_ADD, 1, 0);
        send_item(gcol_pkg::OP_ADD, 2, 3);
        send_item(gcol_pkg::OP_ADD, 3, 2);
        send_item(gcol_pkg::OP_ADD, 3, 1023);
        send_item(gcol_pkg::OP_ADD, 3, 1);
        send_item(gcol_pkg::OP_RUN, 0, 0);
        for (int i = 0; i < 4; i++) send_item(gcol_pkg::OP_READ, i, 0);

        ph = 0;
        while (items_sent < 520)
        begin
            steady = (ph == 4 || ph == 5);
            graph_phase(ph);
            ph++;
        end
        steady = 1'b0;

        drain();
        repeat (200) @(negedge clk);
        if (sb.errors == 0)
            $display("** greedy_graph_coloring_engine: PASSED **");
        else
            $display("** greedy_graph_coloring_engine: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire

### greedy_graph_coloring_engine.f
hw/rtl/gcol_pkg.sv
hw/rtl/gcol_front.sv
hw/rtl/gcol_queue.sv
hw/rtl/gcol_back.sv
hw/rtl/greedy_graph_coloring_engine.sv
verif/tb_top.sv
